@@ sv/srsw_pkg.sv @@
`timescale 1ns / 1ps
// Package for the selective-repeat sender window.
// Shared types, widths, command codes and unit request/response structs. No dependencies.
package srsw_pkg;

  localparam int DEF_MAX_WINDOW   = 8;
  localparam int DEF_PAYLOAD_BITS = 64;

  localparam int PAYLOAD_W   = 64;  // payload field on the channels
  localparam int CMD_W       = 2;
  localparam int SEQ_FIELD_W = 4;   // sequence number fields on the channels
  localparam int SEQ_W       = 6;   // internal base / next and base + W
  localparam int WIN_W       = 4;
  localparam int CNT_FIELD_W = 4;

  localparam int APB_DATA_W = 32;
  localparam int ADDR_W     = 3;

  localparam logic [WIN_W-1:0] WIN_RESET = 4'd4;
  localparam logic [0:0] REG_WINDOW_SIZE = 1'b0;

  typedef enum logic [CMD_W-1:0] {
    CMD_SEND    = 2'd0,
    CMD_ACK     = 2'd1,
    CMD_TIMEOUT = 2'd2
  } srsw_cmd_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PRE_START,
    S_PRE_WAIT,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_BASE,
    S_BASE_WAIT,
    S_POST_START,
    S_POST_WAIT,
    S_RESULT
  } srsw_state_e;

  typedef struct packed {
    logic             start;
    logic [SEQ_W-1:0] dividend;
    logic [SEQ_W-1:0] divisor;
  } mod_req_t;

  typedef struct packed {
    logic             done;
    logic [SEQ_W-1:0] rem;
  } mod_rsp_t;

  typedef struct packed {
    logic                   accepted;
    logic                   transmit;
    logic [SEQ_FIELD_W-1:0] tx_seq;
    logic [PAYLOAD_W-1:0]   tx_payload;
    logic                   timer_start;
    logic                   timer_stop;
    logic [SEQ_FIELD_W-1:0] timer_seq;
    logic [SEQ_FIELD_W-1:0] window_base;
    logic [SEQ_FIELD_W-1:0] next_seq;
    logic                   window_full;
    logic [CNT_FIELD_W-1:0] pending_count;
  } srsw_result_t;

endpackage

@@ sv/srsw_if.sv @@
`timescale 1ns / 1ps
// Valid/ready channel interfaces for event input and result output.
// Depends on srsw_pkg for field widths.
interface srsw_in_if;
  logic                                valid;
  logic                                ready;
  logic [srsw_pkg::CMD_W-1:0]          command;
  logic [srsw_pkg::PAYLOAD_W-1:0]      payload;
  logic [srsw_pkg::SEQ_FIELD_W-1:0]    seq_num;
  logic                                ack_ok;

  modport source (output valid, command, payload, seq_num, ack_ok, input ready);
  modport sink   (input valid, command, payload, seq_num, ack_ok, output ready);
endinterface

interface srsw_out_if;
  logic                                valid;
  logic                                ready;
  logic                                accepted;
  logic                                transmit;
  logic [srsw_pkg::SEQ_FIELD_W-1:0]    tx_seq;
  logic [srsw_pkg::PAYLOAD_W-1:0]      tx_payload;
  logic                                timer_start;
  logic                                timer_stop;
  logic [srsw_pkg::SEQ_FIELD_W-1:0]    timer_seq;
  logic [srsw_pkg::SEQ_FIELD_W-1:0]    window_base;
  logic [srsw_pkg::SEQ_FIELD_W-1:0]    next_seq;
  logic                                window_full;
  logic [srsw_pkg::CNT_FIELD_W-1:0]    pending_count;

  modport source (output valid, accepted, transmit, tx_seq, tx_payload, timer_start,
                  timer_stop, timer_seq, window_base, next_seq, window_full,
                  pending_count, input ready);
  modport sink   (input valid, accepted, transmit, tx_seq, tx_payload, timer_start,
                  timer_stop, timer_seq, window_base, next_seq, window_full,
                  pending_count, output ready);
endinterface

@@ sv/selective_repeat_sender_window.sv @@
`timescale 1ns / 1ps
// Selective-repeat ARQ sender window: top level with sequencer and config register.
// Depends on srsw_pkg, srsw_if, srsw_ram, srsw_mod.
//
// Usage:
//   in_i carries one event per transfer: send (payload), ack (seq_num, ack_ok)
//   or timer expiry (seq_num). out_o returns exactly one result per event:
//   transmit / timer actions plus window_base, next_seq, window_full and
//   pending_count after the event. window_size (reset value 4) is written over
//   APB at address 0; the user writes it only while idle, unenforced by the block.
// Sequencing:
//   One event at a time; in_i.ready is high only in idle, which is entered
//   as a result is registered. The modulo reducer (one subtract per cycle)
//   runs before the update of a send and after every update for the full
//   flag. An ack with ack_ok and a timeout walk the buffer RAM through its
//   single read port to search for the entry; such an ack also compacts the
//   entries behind the removed one.
// Reset: buffer empty, base and next sequence 0, no result pending.
// Stall: a finished result waits in the output register; the next event is
//   taken meanwhile and its result is held until the register frees up.
module selective_repeat_sender_window import srsw_pkg::*; #(
  parameter int MAX_WINDOW   = DEF_MAX_WINDOW,
  parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  srsw_in_if.sink               in_i,
  srsw_out_if.source            out_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_W-1:0]     paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int CNT_W   = $clog2(MAX_WINDOW + 1);
  localparam int IDX_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int ENTRY_W = SEQ_FIELD_W + PAYLOAD_BITS;
  localparam int SEQ_SPAN = 2 * ((MAX_WINDOW < 15) ? MAX_WINDOW : 15);

  srsw_state_e state_q, state_d;

  logic [WIN_W-1:0]        win_q;
  srsw_cmd_e               cmd_q;
  logic [PAYLOAD_BITS-1:0] pay_q;
  logic [SEQ_FIELD_W-1:0]  seq_q;
  logic [CNT_W-1:0]        total_q;
  logic [CNT_W-1:0]        idx_q;
  logic [SEQ_W-1:0]        base_q;
  logic [SEQ_W-1:0]        next_q;
  srsw_result_t            res_q;
  srsw_result_t            out_q;
  logic                    out_valid_q;
  logic                    out_valid_d;

  srsw_cmd_e               in_cmd;
  logic                    in_fire;
  logic                    out_free;
  logic [WIN_W-1:0]        w_eff;
  logic [SEQ_W-1:0]        two_w;
  logic [SEQ_FIELD_W-1:0]  cur_seq;
  logic [SEQ_W-1:0]        nxt_inc;
  logic [SEQ_W-1:0]        nxt_wrap;
  logic [CNT_W-1:0]        idx_inc;
  logic                    full_now;
  logic                    match;
  srsw_result_t            res_init;
  srsw_result_t            res_fin;

  mod_req_t                mod_req;
  mod_rsp_t                mod_rsp;

  logic                    mem_we;
  logic [IDX_W-1:0]        mem_waddr;
  logic [IDX_W-1:0]        mem_raddr;
  logic [ENTRY_W-1:0]      mem_wdata;
  logic [ENTRY_W-1:0]      mem_rdata;
  logic [SEQ_FIELD_W-1:0]  rd_seq;
  logic [PAYLOAD_BITS-1:0] rd_pay;

  srsw_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_WINDOW)
  ) u_buf (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  srsw_mod u_mod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mod_req),
    .rsp_o  (mod_rsp)
  );

  // effective window: 0 -> 1, clamp to MAX_WINDOW
  always_comb begin
    if (win_q == '0) begin
      w_eff = WIN_W'(1);
    end else if (int'(win_q) > MAX_WINDOW) begin
      w_eff = WIN_W'(MAX_WINDOW);
    end else begin
      w_eff = win_q;
    end
  end

  assign two_w    = SEQ_W'({w_eff, 1'b0});
  assign cur_seq  = next_q[SEQ_FIELD_W-1:0];
  assign nxt_inc  = SEQ_W'(cur_seq) + SEQ_W'(1);
  assign nxt_wrap = (nxt_inc >= two_w) ? '0 : nxt_inc;
  assign idx_inc  = idx_q + CNT_W'(1);
  assign rd_seq   = mem_rdata[ENTRY_W-1 -: SEQ_FIELD_W];
  assign rd_pay   = mem_rdata[PAYLOAD_BITS-1:0];
  assign match    = (rd_seq == seq_q);
  assign full_now = (int'(total_q) >= MAX_WINDOW) || (mod_rsp.rem == next_q);

  assign in_cmd   = srsw_cmd_e'(in_i.command);
  assign in_fire  = in_i.valid && in_i.ready;
  assign out_free = !out_valid_q || out_o.ready;

  // timer fields known at the input transfer
  always_comb begin
    res_init = '0;
    if ((in_cmd == CMD_ACK) && in_i.ack_ok) begin
      res_init.timer_stop = 1'b1;
      res_init.timer_seq  = in_i.seq_num;
    end else if (in_cmd == CMD_TIMEOUT) begin
      res_init.timer_start = 1'b1;
      res_init.timer_seq   = in_i.seq_num;
    end
  end

  // status fields after the update
  always_comb begin
    res_fin               = res_q;
    res_fin.window_base   = base_q[SEQ_FIELD_W-1:0];
    res_fin.next_seq      = next_q[SEQ_FIELD_W-1:0];
    res_fin.pending_count = CNT_FIELD_W'(total_q);
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_o.valid && out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if ((state_q == S_RESULT) && out_free) begin
      out_valid_d = 1'b1;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_cmd)
            CMD_SEND:    state_d = S_PRE_START;
            CMD_ACK:     state_d = in_i.ack_ok ? S_SCAN_RD : S_POST_START;
            CMD_TIMEOUT: state_d = S_SCAN_RD;
            default:     state_d = S_POST_START;
          endcase
        end
      end
      S_PRE_START: state_d = S_PRE_WAIT;
      S_PRE_WAIT: begin
        if (mod_rsp.done) begin
          state_d = full_now ? S_RESULT : S_POST_START;
        end
      end
      S_SCAN_RD: begin
        if (idx_q >= total_q) begin
          state_d = (cmd_q == CMD_ACK) ? S_BASE : S_POST_START;
        end else begin
          state_d = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (match) begin
          state_d = (cmd_q == CMD_ACK) ? S_SHIFT_RD : S_POST_START;
        end else begin
          state_d = S_SCAN_RD;
        end
      end
      S_SHIFT_RD:   state_d = (idx_inc >= total_q) ? S_BASE : S_SHIFT_WR;
      S_SHIFT_WR:   state_d = S_SHIFT_RD;
      S_BASE:       state_d = (total_q == '0) ? S_POST_START : S_BASE_WAIT;
      S_BASE_WAIT:  state_d = S_POST_START;
      S_POST_START: state_d = S_POST_WAIT;
      S_POST_WAIT: begin
        if (mod_rsp.done) begin
          state_d = S_RESULT;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_i.ready       = (state_q == S_IDLE);
    mod_req.start    = (state_q == S_PRE_START) || (state_q == S_POST_START);
    mod_req.dividend = base_q + SEQ_W'(w_eff);
    mod_req.divisor  = two_w;
    mem_we           = 1'b0;
    mem_waddr        = idx_q[IDX_W-1:0];
    mem_wdata        = mem_rdata;
    mem_raddr        = idx_q[IDX_W-1:0];
    unique case (state_q)
      S_PRE_WAIT: begin
        if (mod_rsp.done && !full_now) begin
          mem_we    = 1'b1;
          mem_waddr = total_q[IDX_W-1:0];
          mem_wdata = {cur_seq, pay_q};
        end
      end
      S_SHIFT_RD: mem_raddr = idx_inc[IDX_W-1:0];
      S_SHIFT_WR: mem_we = 1'b1;
      S_BASE:     mem_raddr = '0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q       <= WIN_RESET;
      total_q     <= '0;
      base_q      <= '0;
      next_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && (paddr[ADDR_W-1] == REG_WINDOW_SIZE)) begin
        win_q <= pwdata[WIN_W-1:0];
      end
      out_valid_q <= out_valid_d;
      unique case (state_q)
        S_PRE_WAIT: begin
          if (mod_rsp.done && !full_now) begin
            total_q <= total_q + CNT_W'(1);
            next_q  <= nxt_wrap;
          end
        end
        S_SHIFT_RD: begin
          if (idx_inc >= total_q) begin
            total_q <= total_q - CNT_W'(1);
          end
        end
        S_BASE: begin
          if (total_q == '0) begin
            base_q <= next_q;
          end
        end
        S_BASE_WAIT: base_q <= SEQ_W'(rd_seq);
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          cmd_q <= in_cmd;
          pay_q <= in_i.payload[PAYLOAD_BITS-1:0];
          seq_q <= in_i.seq_num;
          idx_q <= '0;
          res_q <= res_init;
        end
      end
      S_PRE_WAIT: begin
        if (mod_rsp.done) begin
          if (full_now) begin
            res_q.window_full <= 1'b1;
          end else begin
            res_q.accepted    <= 1'b1;
            res_q.transmit    <= 1'b1;
            res_q.tx_seq      <= cur_seq;
            res_q.tx_payload  <= PAYLOAD_W'(pay_q);
            res_q.timer_start <= 1'b1;
            res_q.timer_seq   <= cur_seq;
          end
        end
      end
      S_SCAN_CMP: begin
        if (match) begin
          if (cmd_q == CMD_TIMEOUT) begin
            res_q.transmit   <= 1'b1;
            res_q.tx_seq     <= rd_seq;
            res_q.tx_payload <= PAYLOAD_W'(rd_pay);
          end
        end else begin
          idx_q <= idx_inc;
        end
      end
      S_SHIFT_WR: idx_q <= idx_inc;
      S_POST_WAIT: begin
        if (mod_rsp.done) begin
          res_q.window_full <= full_now;
        end
      end
      S_RESULT: begin
        if (out_free) begin
          out_q <= res_fin;
        end
      end
      default: ;
    endcase
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.accepted      = out_q.accepted;
  assign out_o.transmit      = out_q.transmit;
  assign out_o.tx_seq        = out_q.tx_seq;
  assign out_o.tx_payload    = out_q.tx_payload;
  assign out_o.timer_start   = out_q.timer_start;
  assign out_o.timer_stop    = out_q.timer_stop;
  assign out_o.timer_seq     = out_q.timer_seq;
  assign out_o.window_base   = out_q.window_base;
  assign out_o.next_seq      = out_q.next_seq;
  assign out_o.window_full   = out_q.window_full;
  assign out_o.pending_count = out_q.pending_count;

  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1] == REG_WINDOW_SIZE) ? APB_DATA_W'(win_q) : '0;

  a_total_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= CNT_W'(MAX_WINDOW))
    else $error("buffer count above MAX_WINDOW");

  a_next_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(next_q) < SEQ_SPAN)
    else $error("next sequence out of range");

  a_scan_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN_CMP) |-> (idx_q < total_q))
    else $error("search read past buffered entries");

  a_accept_tx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.accepted |->
      out_q.transmit && out_q.timer_start && (out_q.tx_seq == out_q.timer_seq))
    else $error("accepted send without matching transmit and timer start");

endmodule

@@ sv/srsw_ram.sv @@
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module srsw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/srsw_mod.sv @@
`timescale 1ns / 1ps
// Iterative modulo reducer: one compare-and-subtract per cycle.
// Depends on srsw_pkg (mod_req_t, mod_rsp_t).
module srsw_mod import srsw_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mod_req_t req_i,
  output mod_rsp_t rsp_o
);

  logic             busy_q;
  logic [SEQ_W-1:0] rem_q;
  logic [SEQ_W-1:0] div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
    end else if (rsp_o.done) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      rem_q <= req_i.dividend;
      div_q <= req_i.divisor;
    end else if (busy_q && (rem_q >= div_q)) begin
      rem_q <= rem_q - div_q;
    end
  end

  assign rsp_o.done = busy_q && (rem_q < div_q);
  assign rsp_o.rem  = rem_q;

  a_rem_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !rsp_o.done && !req_i.start |=> rem_q < $past(rem_q))
    else $error("modulo remainder did not shrink");

endmodule
